FILE: hw/rtl/ntfs_rld_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// NTFS run list decoder package
// Shared constants, codes and the result record of the run list decoder.
// ----------------------------------------------------------------------------
package ntfs_rld_pkg;

	// Largest header sizes that still describe a run.
	localparam int MAX_LENGTH_BYTES = 4;
	localparam int MAX_OFFSET_BYTES = 8;

	// Field widths.
	localparam int BYTE_W    = 8;
	localparam int KIND_W    = 2;
	localparam int LENGTH_W  = 32;
	localparam int CLUSTER_W = 64;
	localparam int RUN_W     = 8;

	// Byte lanes of the length and offset words.
	localparam int LEN_LANES = LENGTH_W / BYTE_W;
	localparam int OFF_LANES = CLUSTER_W / BYTE_W;

	// Counter widths: each must hold its maximum size itself.
	localparam int LEN_CNT_W = $clog2(MAX_LENGTH_BYTES + 1);
	localparam int OFF_CNT_W = $clog2(MAX_OFFSET_BYTES + 1);
	localparam int BCNT_W    = (LEN_CNT_W > OFF_CNT_W) ? LEN_CNT_W : OFF_CNT_W;

	// Header nibble width.
	localparam int NIB_W = 4;

	// Saturation value of the run counter.
	localparam logic [RUN_W-1:0] RUN_MAX = {RUN_W{1'b1}};

	// Result kinds.
	typedef enum logic [KIND_W-1:0] {
		KIND_RUN  = 2'd0,
		KIND_TERM = 2'd1,
		KIND_CUT  = 2'd2
	} kind_t;

	// Parser phases, one-hot.
	typedef enum logic [3:0] {
		PH_HEADER = 4'b0001,
		PH_LENGTH = 4'b0010,
		PH_OFFSET = 4'b0100,
		PH_SKIP   = 4'b1000
	} phase_t;

	// One result item as it leaves the parser.
	typedef struct packed {
		kind_t                        kind;
		logic [LENGTH_W-1:0]          run_length;
		logic signed [CLUSTER_W-1:0]  start_cluster;
		logic [RUN_W-1:0]             run_number;
		logic                         list_done;
	} result_t;

endpackage

FILE: hw/rtl/ntfs_rld_in_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// NTFS run list decoder input channel
// Carries one run list byte and its final-byte flag per transfer.
// ----------------------------------------------------------------------------
interface ntfs_rld_in_if;
	import ntfs_rld_pkg::*;

	logic              valid;
	logic              ready;
	logic [BYTE_W-1:0] data_byte;
	logic              final_byte;

	modport source (output valid, output data_byte, output final_byte, input ready);
	modport sink   (input valid, input data_byte, input final_byte, output ready);

endinterface

FILE: hw/rtl/ntfs_rld_out_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// NTFS run list decoder result channel
// Carries one decoded run, terminator or cut-off report per transfer.
// ----------------------------------------------------------------------------
interface ntfs_rld_out_if;
	import ntfs_rld_pkg::*;

	logic                        valid;
	logic                        ready;
	logic [KIND_W-1:0]           kind;
	logic [LENGTH_W-1:0]         run_length;
	logic signed [CLUSTER_W-1:0] start_cluster;
	logic [RUN_W-1:0]            run_number;
	logic                        list_done;

	modport source (output valid, output kind, output run_length, output start_cluster,
		output run_number, output list_done, input ready);
	modport sink   (input valid, input kind, input run_length, input start_cluster,
		input run_number, input list_done, output ready);

endinterface

FILE: hw/rtl/ntfs_rld_parser.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// NTFS run list parser
// Holds the run list state and turns one byte per step into at most one
// result: header decode, little-endian length and offset assembly, and the
// running cluster sum.
// ----------------------------------------------------------------------------
module ntfs_rld_parser (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            step,
	input  logic [ntfs_rld_pkg::BYTE_W-1:0] data_byte,
	input  logic                            final_byte,
	output logic                            res_valid,
	output ntfs_rld_pkg::result_t           res
);
	import ntfs_rld_pkg::*;

	phase_t                      phase_q, phase_d;
	logic [LEN_CNT_W-1:0]        len_bytes_q, len_bytes_d;
	logic [OFF_CNT_W-1:0]        off_bytes_q, off_bytes_d;
	logic [BCNT_W-1:0]           bcnt_q, bcnt_d;
	logic [LENGTH_W-1:0]         len_acc_q, len_acc_d;
	logic [CLUSTER_W-1:0]        off_acc_q, off_acc_d;
	logic [CLUSTER_W-1:0]        cluster_q, cluster_d;
	logic [RUN_W-1:0]            run_q, run_d;

	logic [NIB_W-1:0]            hdr_len, hdr_off;
	logic                        hdr_bad;
	logic [BCNT_W-1:0]           bcnt_inc;
	logic [LENGTH_W-1:0]         len_next;
	logic [CLUSTER_W-1:0]        off_next;
	logic [CLUSTER_W-1:0]        add_operand;
	logic [CLUSTER_W-1:0]        cluster_sum;
	logic                        len_full, off_full;

	// Header nibbles and the terminator test.
	assign hdr_len = data_byte[NIB_W-1:0];
	assign hdr_off = data_byte[BYTE_W-1:NIB_W];
	assign hdr_bad = (hdr_len == '0) || (hdr_len > NIB_W'(MAX_LENGTH_BYTES))
		|| (hdr_off > NIB_W'(MAX_OFFSET_BYTES));

	assign bcnt_inc = bcnt_q + 1'b1;
	assign len_full = bcnt_inc >= BCNT_W'(len_bytes_q);
	assign off_full = bcnt_inc >= BCNT_W'(off_bytes_q);

	// Length word with the current byte placed in its lane.
	always_comb begin
		len_next = len_acc_q;
		for (int k = 0; k < LEN_LANES; k++) begin
			if (bcnt_q == BCNT_W'(k)) begin
				len_next[k*BYTE_W +: BYTE_W] = data_byte;
			end
		end
	end

	// Offset word with the current byte in its lane and its sign copied into
	// every lane above, so the word is sign-extended once the last byte lands.
	always_comb begin
		off_next = off_acc_q;
		for (int k = 0; k < OFF_LANES; k++) begin
			if (bcnt_q == BCNT_W'(k)) begin
				off_next[k*BYTE_W +: BYTE_W] = data_byte;
			end else if (BCNT_W'(k) > bcnt_q) begin
				off_next[k*BYTE_W +: BYTE_W] = {BYTE_W{data_byte[BYTE_W-1]}};
			end
		end
	end

	// A run without offset bytes leaves the running cluster unchanged.
	assign add_operand = (phase_q == PH_OFFSET) ? off_next : '0;
	assign cluster_sum = cluster_q + add_operand;

	// Next state and result.
	always_comb begin
		phase_d      = phase_q;
		len_bytes_d  = len_bytes_q;
		off_bytes_d  = off_bytes_q;
		bcnt_d       = bcnt_q;
		len_acc_d    = len_acc_q;
		off_acc_d    = off_acc_q;
		cluster_d    = cluster_q;
		run_d        = run_q;
		res_valid    = 1'b0;
		res.kind          = KIND_RUN;
		res.run_length    = '0;
		res.start_cluster = cluster_q;
		res.run_number    = run_q;
		res.list_done     = 1'b1;

		unique case (phase_q)
			PH_HEADER: begin
				if (hdr_bad) begin
					res_valid = 1'b1;
					res.kind  = KIND_TERM;
					if (final_byte) begin
						cluster_d = '0;
						run_d     = '0;
					end else begin
						phase_d = PH_SKIP;
					end
				end else if (final_byte) begin
					res_valid = 1'b1;
					res.kind  = KIND_CUT;
					cluster_d = '0;
					run_d     = '0;
				end else begin
					len_bytes_d = LEN_CNT_W'(hdr_len);
					off_bytes_d = OFF_CNT_W'(hdr_off);
					bcnt_d      = '0;
					len_acc_d   = '0;
					off_acc_d   = '0;
					phase_d     = PH_LENGTH;
				end
			end
			PH_LENGTH, PH_OFFSET: begin
				len_acc_d = (phase_q == PH_LENGTH) ? len_next : len_acc_q;
				off_acc_d = (phase_q == PH_OFFSET) ? off_next : off_acc_q;
				bcnt_d    = bcnt_inc;
				if ((phase_q == PH_LENGTH) ? len_full : off_full) begin
					bcnt_d = '0;
					if ((phase_q == PH_OFFSET) || (off_bytes_q == '0)) begin
						// The run is complete.
						res_valid         = 1'b1;
						res.kind          = KIND_RUN;
						res.run_length    = len_acc_d;
						res.start_cluster = cluster_sum;
						res.list_done     = final_byte;
						if (final_byte) begin
							cluster_d = '0;
							run_d     = '0;
							phase_d   = PH_HEADER;
						end else begin
							cluster_d = cluster_sum;
							run_d     = (run_q == RUN_MAX) ? run_q : run_q + 1'b1;
							phase_d   = PH_HEADER;
						end
					end else if (final_byte) begin
						res_valid = 1'b1;
						res.kind  = KIND_CUT;
						cluster_d = '0;
						run_d     = '0;
						phase_d   = PH_HEADER;
					end else begin
						phase_d = PH_OFFSET;
					end
				end else if (final_byte) begin
					// The attribute area ends inside the run.
					res_valid = 1'b1;
					res.kind  = KIND_CUT;
					bcnt_d    = '0;
					cluster_d = '0;
					run_d     = '0;
					phase_d   = PH_HEADER;
				end
			end
			PH_SKIP: begin
				if (final_byte) begin
					cluster_d = '0;
					run_d     = '0;
					phase_d   = PH_HEADER;
				end
			end
			default: begin
				phase_d = PH_HEADER;
			end
		endcase
	end

	// Control state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= PH_HEADER;
			bcnt_q    <= '0;
			cluster_q <= '0;
			run_q     <= '0;
		end else if (step) begin
			phase_q   <= phase_d;
			bcnt_q    <= bcnt_d;
			cluster_q <= cluster_d;
			run_q     <= run_d;
		end
	end

	// Run fields, reloaded by every valid header before use.
	always_ff @(posedge clk) begin
		if (step) begin
			len_bytes_q <= len_bytes_d;
			off_bytes_q <= off_bytes_d;
			len_acc_q   <= len_acc_d;
			off_acc_q   <= off_acc_d;
		end
	end

endmodule

FILE: hw/rtl/ntfs_run_list_decoder_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// NTFS run list decoder
// Decodes the data run list of one non-resident attribute, one byte per
// transfer, into run lengths and absolute starting clusters.
//
//   Channel  Direction  Payload
//   item     in         data_byte[7:0], final_byte
//   result   out        kind[1:0], run_length[31:0], start_cluster[63:0],
//                       run_number[7:0], list_done
//
// One byte is taken per cycle unless a stalled result holds the input. A
// byte passes an input register, the parser logic and the result register;
// the 64-bit cluster add sets the cycle time.
// Reset returns the parser to expecting the first header of a new list.
// While a result waits in the output register, the input register still
// holds one byte; further bytes wait until the result is taken.
// ----------------------------------------------------------------------------
module ntfs_run_list_decoder_unit (
	input  logic           clk,
	input  logic           arst_n,
	ntfs_rld_in_if.sink    item,
	ntfs_rld_out_if.source result
);
	import ntfs_rld_pkg::*;

	logic              valid_s1;
	logic [BYTE_W-1:0] byte_s1;
	logic              final_s1;
	logic              advance;
	logic              res_valid;
	result_t           res;
	logic              out_valid_q;
	result_t           out_q;

	// The parser steps whenever the result register can take its output.
	assign advance    = !out_valid_q || result.ready;
	assign item.ready = !valid_s1 || advance;

	// Input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (item.ready) begin
			valid_s1 <= item.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (item.valid && item.ready) begin
			byte_s1  <= item.data_byte;
			final_s1 <= item.final_byte;
		end
	end

	ntfs_rld_parser u_parser (
		.clk        (clk),
		.arst_n     (arst_n),
		.step       (valid_s1 && advance),
		.data_byte  (byte_s1),
		.final_byte (final_s1),
		.res_valid  (res_valid),
		.res        (res)
	);

	// Result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= valid_s1 && res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && valid_s1 && res_valid) begin
			out_q <= res;
		end
	end

	assign result.valid         = out_valid_q;
	assign result.kind          = out_q.kind;
	assign result.run_length    = out_q.run_length;
	assign result.start_cluster = out_q.start_cluster;
	assign result.run_number    = out_q.run_number;
	assign result.list_done     = out_q.list_done;

endmodule

FILE: hw/rtl/ntfs_rld_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// NTFS run list decoder checker
// Watches the result channel of the decoder for malformed or unstable results.
// ----------------------------------------------------------------------------
module ntfs_rld_checker (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               res_valid,
	input  logic                               res_ready,
	input  logic [ntfs_rld_pkg::KIND_W-1:0]    kind,
	input  logic [ntfs_rld_pkg::LENGTH_W-1:0]  run_length,
	input  logic [ntfs_rld_pkg::CLUSTER_W-1:0] start_cluster,
	input  logic                               list_done
);
	import ntfs_rld_pkg::*;

	// A stalled result keeps its contents until the transfer.
	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid && $stable(kind) && $stable(run_length)
			&& $stable(start_cluster) && $stable(list_done))
		else $error("result changed while stalled");

	// Only the three defined kinds are produced.
	a_kind_code: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> (kind == KIND_RUN) || (kind == KIND_TERM) || (kind == KIND_CUT))
		else $error("undefined result kind");

	// Terminator and cut-off reports always close the list.
	a_end_closes: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && (kind != KIND_RUN) |-> list_done)
		else $error("list end without list_done");

	// Terminator and cut-off reports carry no run length.
	a_end_no_len: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && (kind != KIND_RUN) |-> (run_length == '0))
		else $error("list end with nonzero run length");

endmodule

bind ntfs_run_list_decoder_unit ntfs_rld_checker u_ntfs_rld_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.res_valid     (result.valid),
	.res_ready     (result.ready),
	.kind          (result.kind),
	.run_length    (result.run_length),
	.start_cluster (result.start_cluster),
	.list_done     (result.list_done)
);

FILE: bench/tb_ntfs_run_list_decoder_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// NTFS run list decoder testbench
// Feeds run list bytes into the decoder and checks every decoded run,
// terminator and cut-off report against a cycle-free decoding model kept in
// the testbench. Directed byte sequences come first. Random well-formed lists,
// broken lists and noise follow, with random idle bursts on both channels, a
// long receiver hold-off and a run counter saturation list.
// ----------------------------------------------------------------------------
module tb_ntfs_run_list_decoder_unit;
	import ntfs_rld_pkg::*;

	localparam int CLK_HALF       = 5;
	localparam int RESET_CYCLES   = 5;
	localparam int WATCHDOG_LIMIT = 2000;
	localparam int DRAIN_CYCLES   = 10;
	localparam int HOLD_CYCLES    = 300;

	// How a random list is closed.
	typedef enum int {
		END_ON_RUN,
		END_TERMINATOR,
		END_CUT
	} list_end_t;

	logic clk;
	logic arst_n;

	ntfs_rld_in_if  in_ch ();
	ntfs_rld_out_if out_ch ();

	ntfs_run_list_decoder_unit u_top (
		.clk    (clk),
		.arst_n (arst_n),
		.item   (in_ch.sink),
		.result (out_ch.source)
	);

	// Decoder model state.
	phase_t             rl_phase;
	logic [2:0]         len_size;
	logic [3:0]         off_size;
	logic [3:0]         byte_idx;
	logic [LENGTH_W-1:0]  len_acc;
	logic [CLUSTER_W-1:0] off_acc;
	logic [CLUSTER_W-1:0] cluster;
	logic [RUN_W-1:0]     run_cnt;

	result_t expected_runs[$];
	result_t exp_r;

	int errors       = 0;
	int bytes_sent   = 0;
	int quiet_cycles = 0;
	int hold_req     = 0;
	int hold_left    = 0;
	int stall_left   = 0;
	bit in_gaps_on    = 1'b1;
	bit out_stalls_on = 1'b1;

	// Clock generation.
	initial clk = 1'b0;
	always #CLK_HALF clk = ~clk;

	// ------------------------------------------------------------------------
	// Decoding model
	// ------------------------------------------------------------------------

	function automatic void push_result(input kind_t k, input logic [LENGTH_W-1:0] len,
		input logic done);
		result_t r;
		r.kind          = k;
		r.run_length    = len;
		r.start_cluster = cluster;
		r.run_number    = run_cnt;
		r.list_done     = done;
		expected_runs.push_back(r);
	endfunction

	function automatic void clear_list();
		rl_phase = PH_HEADER;
		len_size = '0;
		off_size = '0;
		byte_idx = '0;
		len_acc  = '0;
		off_acc  = '0;
		cluster  = '0;
		run_cnt  = '0;
	endfunction

	// Adds the sign-extended offset to the running cluster and reports the run.
	function automatic void finish_run(input logic is_last);
		logic [6:0]                  sh;
		logic signed [CLUSTER_W-1:0] shifted;
		logic [CLUSTER_W-1:0]        ext;
		if (off_size != 0) begin
			if (off_size >= 8) begin
				ext = off_acc;
			end else begin
				sh      = 7'(64 - 8 * off_size);
				shifted = off_acc << sh;
				ext     = shifted >>> sh;
			end
			cluster = cluster + ext;
		end
		push_result(KIND_RUN, len_acc, is_last);
		if (run_cnt != RUN_MAX)
			run_cnt = run_cnt + 1'b1;
		if (is_last)
			clear_list();
		else
			rl_phase = PH_HEADER;
	endfunction

	// Advances the model by one byte and queues the result it causes, if any.
	function automatic void decode_byte(input logic [7:0] b, input logic is_last);
		logic [3:0] ln;
		logic [3:0] on;
		case (rl_phase)
			PH_HEADER: begin
				ln = b[3:0];
				on = b[7:4];
				if (ln == 0 || ln > MAX_LENGTH_BYTES || on > MAX_OFFSET_BYTES) begin
					push_result(KIND_TERM, '0, 1'b1);
					if (is_last)
						clear_list();
					else
						rl_phase = PH_SKIP;
				end else if (is_last) begin
					push_result(KIND_CUT, '0, 1'b1);
					clear_list();
				end else begin
					len_size = ln[2:0];
					off_size = on;
					byte_idx = '0;
					len_acc  = '0;
					off_acc  = '0;
					rl_phase = PH_LENGTH;
				end
			end
			PH_LENGTH: begin
				if (byte_idx < LEN_LANES)
					len_acc = len_acc | ({24'd0, b} << (8 * byte_idx));
				byte_idx = byte_idx + 1'b1;
				if (byte_idx >= len_size) begin
					byte_idx = '0;
					if (off_size == 0) begin
						finish_run(is_last);
					end else if (is_last) begin
						push_result(KIND_CUT, '0, 1'b1);
						clear_list();
					end else begin
						rl_phase = PH_OFFSET;
					end
				end else if (is_last) begin
					push_result(KIND_CUT, '0, 1'b1);
					clear_list();
				end
			end
			PH_OFFSET: begin
				if (byte_idx < OFF_LANES)
					off_acc = off_acc | ({56'd0, b} << (8 * byte_idx));
				byte_idx = byte_idx + 1'b1;
				if (byte_idx >= off_size) begin
					byte_idx = '0;
					finish_run(is_last);
				end else if (is_last) begin
					push_result(KIND_CUT, '0, 1'b1);
					clear_list();
				end
			end
			default: begin
				if (is_last)
					clear_list();
			end
		endcase
	endfunction

	// ------------------------------------------------------------------------
	// Stimulus helpers
	// ------------------------------------------------------------------------

	// Random byte with extra weight on the edge values.
	function automatic logic [7:0] rnd_byte();
		case ($urandom_range(0, 11))
			0:       return 8'h00;
			1:       return 8'hFF;
			2:       return 8'h80;
			3:       return 8'h7F;
			default: return 8'($urandom_range(0, 255));
		endcase
	endfunction

	// Header that ends a list: zero length size, oversized length or offset size.
	function automatic logic [7:0] bad_header();
		case ($urandom_range(0, 2))
			0:       return {4'($urandom_range(0, 15)), 4'd0};
			1:       return {4'($urandom_range(0, 15)),
				4'($urandom_range(MAX_LENGTH_BYTES + 1, 15))};
			default: return {4'($urandom_range(MAX_OFFSET_BYTES + 1, 15)),
				4'($urandom_range(0, 15))};
		endcase
	endfunction

	// Offers one byte and returns at the edge where the transfer happens.
	task automatic send_byte(input logic [7:0] b, input logic is_last);
		if (in_gaps_on && $urandom_range(0, 5) == 0) begin
			in_ch.valid <= 1'b0;
			repeat ($urandom_range(1, 9)) @(posedge clk);
		end
		in_ch.valid      <= 1'b1;
		in_ch.data_byte  <= b;
		in_ch.final_byte <= is_last;
		decode_byte(b, is_last);
		do @(posedge clk); while (!in_ch.ready);
		bytes_sent++;
	endtask

	// One complete run with random length and offset bytes.
	task automatic send_run(input int ln, input int on, input logic last_run);
		int total;
		total = ln + on;
		send_byte({4'(on), 4'(ln)}, 1'b0);
		for (int i = 1; i <= total; i++)
			send_byte(rnd_byte(), last_run && i == total);
	endtask

	// A well-formed list of random runs, closed in one of three ways.
	task automatic send_list(input int n_runs);
		list_end_t ending;
		int        ln;
		int        on;
		int        k;
		ending = list_end_t'($urandom_range(0, 2));
		for (int i = 0; i < n_runs; i++)
			send_run($urandom_range(1, MAX_LENGTH_BYTES), $urandom_range(0, MAX_OFFSET_BYTES),
				ending == END_ON_RUN && i == n_runs - 1);
		case (ending)
			END_TERMINATOR: begin
				k = $urandom_range(0, 3);
				send_byte(bad_header(), k == 0);
				for (int j = 1; j <= k; j++)
					send_byte(rnd_byte(), j == k);
			end
			END_CUT: begin
				ln = $urandom_range(1, MAX_LENGTH_BYTES);
				on = $urandom_range(0, MAX_OFFSET_BYTES);
				k  = $urandom_range(0, ln + on - 1);
				send_byte({4'(on), 4'(ln)}, k == 0);
				for (int j = 1; j <= k; j++)
					send_byte(rnd_byte(), j == k);
			end
			default: ;
		endcase
	endtask

	// ------------------------------------------------------------------------
	// Tests
	// ------------------------------------------------------------------------

	// Size extremes, sign extension and every way a list can end.
	task automatic test_directed();
		// Smallest length value, positive one-byte offset.
		send_byte(8'h11, 1'b0); send_byte(8'h00, 1'b0); send_byte(8'h7F, 1'b0);
		// Four-byte length of all ones, negative three-byte offset.
		send_byte(8'h34, 1'b0);
		send_byte(8'hFF, 1'b0); send_byte(8'hFF, 1'b0);
		send_byte(8'hFF, 1'b0); send_byte(8'hFF, 1'b0);
		send_byte(8'h00, 1'b0); send_byte(8'h00, 1'b0); send_byte(8'h80, 1'b0);
		// Run without an offset keeps the cluster.
		send_byte(8'h01, 1'b0); send_byte(8'h02, 1'b0);
		// Five-byte negative offset, run ends on the last byte of the area.
		send_byte(8'h51, 1'b0); send_byte(8'h01, 1'b0);
		send_byte(8'h00, 1'b0); send_byte(8'h00, 1'b0); send_byte(8'h00, 1'b0);
		send_byte(8'h00, 1'b0); send_byte(8'h80, 1'b1);
		// Terminator header, skipped bytes, then the last byte.
		send_byte(8'h00, 1'b0); send_byte(8'hAA, 1'b0); send_byte(8'h55, 1'b1);
		// Last byte on a valid header.
		send_byte(8'h11, 1'b1);
		// Last byte inside the length field.
		send_byte(8'h12, 1'b0); send_byte(8'h01, 1'b1);
		// Last byte inside the offset field.
		send_byte(8'h21, 1'b0); send_byte(8'h01, 1'b0); send_byte(8'h01, 1'b1);
		// Oversized offset size and oversized length size as last bytes.
		send_byte(8'h91, 1'b1);
		send_byte(8'h05, 1'b1);
	endtask

	task automatic test_random_lists();
		int target;
		target = bytes_sent + 40;
		while (bytes_sent < target)
			send_list($urandom_range(1, 6));
	endtask

	// The receiver holds off while short runs keep coming, so the block fills.
	task automatic test_backpressure();
		in_gaps_on = 1'b0;
		hold_req   = HOLD_CYCLES;
		repeat (8)
			send_run(1, $urandom_range(0, 1), 1'b0);
		send_byte(8'h00, 1'b1);
		in_gaps_on = 1'b1;
	endtask

	// More than 255 runs in one list drive the run number into saturation.
	task automatic test_run_counter_saturation();
		repeat (258)
			send_run(1, 0, 1'b0);
		send_byte(8'h00, 1'b1);
	endtask

	// Random bytes with random last-byte flags, between well-formed lists.
	task automatic test_noise();
		int n;
		repeat (2) begin
			n = $urandom_range(5, 12);
			for (int i = 1; i <= n; i++)
				send_byte(8'($urandom_range(0, 255)), i == n || $urandom_range(0, 5) == 0);
			send_list($urandom_range(1, 2));
		end
	endtask

	// Closing stretch with no idling on either side.
	task automatic test_streaming();
		int target;
		in_gaps_on    = 1'b0;
		out_stalls_on = 1'b0;
		target = bytes_sent + 30;
		while (bytes_sent < target)
			send_list($urandom_range(1, 6));
	endtask

	// ------------------------------------------------------------------------
	// Result receiver: random stall bursts and the long hold-off.
	// ------------------------------------------------------------------------
	always @(posedge clk) begin
		if (!arst_n) begin
			out_ch.ready <= 1'b0;
		end else begin
			if (hold_req != 0) begin
				hold_left = hold_req;
				hold_req  = 0;
			end
			if (hold_left != 0) begin
				hold_left--;
				out_ch.ready <= 1'b0;
			end else if (stall_left != 0) begin
				stall_left--;
				out_ch.ready <= 1'b0;
			end else if (out_stalls_on && $urandom_range(0, 5) == 0) begin
				stall_left = $urandom_range(0, 8);
				out_ch.ready <= 1'b0;
			end else begin
				out_ch.ready <= 1'b1;
			end
		end
	end

	// ------------------------------------------------------------------------
	// Result check and watchdog.
	// ------------------------------------------------------------------------
	always @(posedge clk) begin
		if (arst_n) begin
			if (out_ch.valid && out_ch.ready) begin
				if (expected_runs.size() == 0) begin
					$error("unexpected result: kind %0d run_length %0d run_number %0d",
						out_ch.kind, out_ch.run_length, out_ch.run_number);
					errors++;
				end else begin
					exp_r = expected_runs.pop_front();
					if (out_ch.kind !== exp_r.kind) begin
						$error("kind: expected %0d, actual %0d", exp_r.kind, out_ch.kind);
						errors++;
					end
					if (out_ch.run_length !== exp_r.run_length) begin
						$error("run_length: expected %0d, actual %0d",
							exp_r.run_length, out_ch.run_length);
						errors++;
					end
					if (out_ch.start_cluster !== exp_r.start_cluster) begin
						$error("start_cluster: expected %0d, actual %0d",
							exp_r.start_cluster, out_ch.start_cluster);
						errors++;
					end
					if (out_ch.run_number !== exp_r.run_number) begin
						$error("run_number: expected %0d, actual %0d",
							exp_r.run_number, out_ch.run_number);
						errors++;
					end
					if (out_ch.list_done !== exp_r.list_done) begin
						$error("list_done: expected %0d, actual %0d",
							exp_r.list_done, out_ch.list_done);
						errors++;
					end
				end
			end
			// Any transfer on either channel counts as progress.
			if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
				quiet_cycles = 0;
			end else begin
				quiet_cycles++;
				if (quiet_cycles >= WATCHDOG_LIMIT) begin
					$display("*** FAILED ***");
					$finish;
				end
			end
		end
	end

	// ------------------------------------------------------------------------
	// Test sequence.
	// ------------------------------------------------------------------------
	initial begin
		arst_n           <= 1'b0;
		in_ch.valid      <= 1'b0;
		in_ch.data_byte  <= '0;
		in_ch.final_byte <= 1'b0;
		clear_list();
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed();
		test_random_lists();
		test_backpressure();
		test_run_counter_saturation();
		test_noise();
		test_streaming();

		// Let the last results drain out of the pipeline.
		in_ch.valid <= 1'b0;
		while (expected_runs.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (errors == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule
